[hdl/maf_pkg.sv]
// maf_pkg: shared constants, sequencer states and control struct for the
// moving average filter. No dependencies; compiled first.

package maf_pkg;

  // fixed field widths of the item channels
  localparam int unsigned SampleW   = 16;
  localparam int unsigned AverageW  = 20;
  localparam int unsigned CountOutW = 4;

  // parameter defaults
  localparam int unsigned DefWindowDepth = 8;
  localparam int unsigned DefSampleBits  = 16;
  localparam int unsigned DefFracBits    = 4;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } maf_state_e;

  // strobes from the sequencer to the datapath
  typedef struct packed {
    logic take;       // input item accepted this cycle
    logic upd;        // write window slot, update sum, pointer, count
    logic div_start;  // load the divider
    logic out_load;   // capture result into the output register
  } maf_ctrl_t;

endpackage

[hdl/maf_sample_if.sv]
// maf_sample_if: valid/ready channel carrying one sensor sample per item.
// Depends on maf_pkg for the field width.

interface maf_sample_if import maf_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);

endinterface

[hdl/maf_result_if.sv]
// maf_result_if: valid/ready channel carrying one window mean per item.
// Depends on maf_pkg for the field widths.

interface maf_result_if import maf_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [AverageW-1:0]  average;
  logic [CountOutW-1:0] valid_count;

  modport source (output valid, output average, output valid_count, input ready);
  modport sink   (input valid, input average, input valid_count, output ready);

endinterface

[hdl/maf_window.sv]
// maf_window: circular sample store, write pointer, fill count and running sum.
// Depends on maf_pkg for the control struct.

module maf_window import maf_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = DefWindowDepth,
  parameter int unsigned SAMPLE_BITS  = DefSampleBits
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  maf_ctrl_t                                     ctrl_i,
  input  logic [SampleW-1:0]                            sample_i,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0]             count_o,
  output logic [SAMPLE_BITS+$clog2(WINDOW_DEPTH)-1:0]   sum_o
);

  localparam int unsigned PtrW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SumW = SAMPLE_BITS + $clog2(WINDOW_DEPTH);

  logic [SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] smp_q;
  logic [SAMPLE_BITS-1:0] rd_q;
  logic [SAMPLE_BITS-1:0] old_smp;
  logic [PtrW-1:0]        wp_q, wp_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [SumW-1:0]        sum_q, sum_d;
  logic                   full;

  // latch the sample and read the slot about to be overwritten
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take) begin
      smp_q <= SAMPLE_BITS'(sample_i);
      rd_q  <= mem[wp_q];
    end
  end

  // store write
  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd) begin
      mem[wp_q] <= smp_q;
    end
  end

  // slots not yet written read as zero until the window is full
  always_comb begin
    full    = (cnt_q == CntW'(WINDOW_DEPTH));
    old_smp = full ? rd_q : '0;
    sum_d   = sum_q - SumW'(old_smp) + SumW'(smp_q);
    wp_d    = (wp_q == PtrW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + PtrW'(1);
    cnt_d   = full ? cnt_q : cnt_q + CntW'(1);
  end

  // pointer, fill count and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      cnt_q <= '0;
      sum_q <= '0;
    end else if (ctrl_i.upd) begin
      wp_q  <= wp_d;
      cnt_q <= cnt_d;
      sum_q <= sum_d;
    end
  end

  assign count_o = cnt_q;
  assign sum_o   = sum_q;

endmodule

[hdl/maf_div.sv]
// maf_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on maf_pkg for the control struct and the parameter defaults.

module maf_div import maf_pkg::*; #(
  parameter int unsigned DIV_W = DefSampleBits + 3 + DefFracBits,
  parameter int unsigned DEN_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  maf_ctrl_t        ctrl_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam int unsigned StepW = $clog2(DIV_W + 1);

  logic [StepW-1:0] step_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quot_q, quot_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // one restoring step: shift in the next dividend bit, trial subtract
  always_comb begin
    trial  = {rem_q, quot_q[DIV_W-1]};
    diff   = trial - {1'b0, den_q};
    ge     = (trial >= {1'b0, den_q});
    rem_d  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    quot_d = {quot_q[DIV_W-2:0], ge};
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (ctrl_i.div_start) begin
      step_q <= StepW'(DIV_W);
    end else if (step_q != '0) begin
      step_q <= step_q - StepW'(1);
    end
  end

  // remainder and dividend/quotient shift register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_start) begin
      den_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= dividend_i;
    end else if (step_q != '0) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign busy_o     = (step_q != '0);
  assign quotient_o = quot_q;

endmodule

[hdl/maf_ctrl.sv]
// maf_ctrl: sequencer stepping one item through update, division and output.
// Depends on maf_pkg for the state enum and control struct.

module maf_ctrl import maf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_free_i,
  input  logic      div_busy_i,
  output logic      in_ready_o,
  output maf_ctrl_t ctrl_o
);

  maf_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_LOAD;
      ST_LOAD:   state_d = ST_DIV;
      ST_DIV:    if (!div_busy_i) state_d = ST_OUT;
      ST_OUT:    if (out_free_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    ctrl_o     = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.take = in_valid_i;
      end
      ST_UPDATE: ctrl_o.upd       = 1'b1;
      ST_LOAD:   ctrl_o.div_start = 1'b1;
      ST_DIV:    ctrl_o           = '0;
      ST_OUT:    ctrl_o.out_load  = out_free_i;
      default:   ctrl_o           = '0;
    endcase
  end

endmodule

[hdl/moving_average_filter_top.sv]
// moving_average_filter_top: windowed mean of sensor samples.
// Depends on maf_pkg, maf_sample_if, maf_result_if, maf_window, maf_div, maf_ctrl.
//
//   channel   direction   payload                         handshake
//   in_i      sink        sample[15:0]                    valid / ready
//   out_o     source      average[19:0], valid_count[3:0] valid / ready
//
// one item at a time: after acceptance the sample passes through UPDATE and LOAD, then
// the bit-serial divider at one quotient bit per cycle, then OUT into the output register;
// the next item is taken once the sequencer is back in IDLE
// the result sits in an output register; the next item is taken while it waits
// a stalled output holds the sequencer only once the next result is ready
// reset clears pointer, fill count, sum and all handshake state at once

module moving_average_filter_top import maf_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = DefWindowDepth,
  parameter int unsigned SAMPLE_BITS  = DefSampleBits,
  parameter int unsigned FRAC_BITS    = DefFracBits
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  maf_sample_if.sink   in_i,
  maf_result_if.source out_o
);

  localparam int unsigned CntW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SumW = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int unsigned DivW = SumW + FRAC_BITS;

  maf_ctrl_t             ctrl;
  logic [CntW-1:0]       count;
  logic [SumW-1:0]       sum;
  logic [DivW-1:0]       dividend;
  logic [DivW-1:0]       quotient;
  logic                  div_busy;
  logic                  out_free;
  logic                  out_valid_q;
  logic [AverageW-1:0]   avg_q;
  logic [CountOutW-1:0]  cnt_q;

  // sequencer
  maf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .out_free_i (out_free),
    .div_busy_i (div_busy),
    .in_ready_o (in_i.ready),
    .ctrl_o     (ctrl)
  );

  // window store and running sum
  maf_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (in_i.sample),
    .count_o  (count),
    .sum_o    (sum)
  );

  // scale the sum to fixed point before dividing by the fill count
  assign dividend = DivW'(sum) << FRAC_BITS;

  maf_div #(
    .DIV_W (DivW),
    .DEN_W (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .dividend_i (dividend),
    .divisor_i  (count),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // output register
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      avg_q <= AverageW'(quotient);
      cnt_q <= CountOutW'(count);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.average     = avg_q;
  assign out_o.valid_count = cnt_q;

  // checks
  a_ready_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !div_busy)
    else $error("input ready while the divider is running");

  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second item taken before the first finished");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntW'(WINDOW_DEPTH))
    else $error("fill count beyond window depth");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> (!out_valid_q || out_o.ready))
    else $error("result overwrote an item not yet taken");

endmodule

[tb/testbench.sv]
// testbench: self-checking bench for moving_average_filter_top, with a windowed mean
// predictor, random sample traffic and random stalls on both channels.
// Depends on maf_pkg, maf_sample_if, maf_result_if and the filter RTL.

module testbench import maf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WinDepth   = DefWindowDepth;
  localparam int unsigned FracBits   = DefFracBits;
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned RandItems  = 450;

  // expected mean and divisor of one result item
  typedef struct packed {
    logic [AverageW-1:0]  average;
    logic [CountOutW-1:0] valid_count;
  } mean_t;

  // tracks the window contents and checks every result item in order
  class mean_scoreboard;
    logic [SampleW-1:0] window_q[WinDepth];
    int unsigned        wr_ptr;
    int unsigned        fill;
    logic [31:0]        sum;
    mean_t              pending_means[$];
    int unsigned        errors;
    int unsigned        checked;

    function new_state();
    endfunction

    function void clear();
      foreach (window_q[i]) window_q[i] = '0;
      wr_ptr  = 0;
      fill    = 0;
      sum     = '0;
      errors  = 0;
      checked = 0;
      pending_means.delete();
    endfunction

    // accepted sample: update the window and queue the mean it causes
    function void note_sample(logic [SampleW-1:0] s);
      mean_t       m;
      logic [31:0] quotient;
      sum              = sum - 32'(window_q[wr_ptr]) + 32'(s);
      window_q[wr_ptr] = s;
      wr_ptr           = (wr_ptr == WinDepth - 1) ? 0 : wr_ptr + 1;
      if (fill < WinDepth) fill++;
      quotient      = (fill != 0) ? (sum << FracBits) / 32'(fill) : '0;
      m.average     = quotient[AverageW-1:0];
      m.valid_count = CountOutW'(fill);
      pending_means.push_back(m);
    endfunction

    // result item: compare with the oldest queued mean
    function void check_result(logic [AverageW-1:0] avg, logic [CountOutW-1:0] cnt);
      mean_t m;
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected result average=%0d valid_count=%0d", $time, avg, cnt);
        errors++;
        return;
      end
      m = pending_means.pop_front();
      checked++;
      if (avg !== m.average) begin
        $display("%0t: average mismatch, expected %0d, actual %0d", $time, m.average, avg);
        errors++;
      end
      if (cnt !== m.valid_count) begin
        $display("%0t: valid_count mismatch, expected %0d, actual %0d",
                 $time, m.valid_count, cnt);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_means.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic no_idle;
  int unsigned quiet_cycles;
  int unsigned drains;
  int unsigned samples_sent;
  mean_scoreboard sb;

  maf_sample_if in_if ();
  maf_result_if out_if ();

  moving_average_filter_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // result side stalls at random outside the steady stretch
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = no_idle ? 1'b1 : ($urandom_range(99) >= 17);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.average, out_if.valid_count);
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, QuietLimit);
      $display("TEST FAILED");
      $finish;
    end
  end

  // present one sample and hold it until accepted, entered at a falling edge
  task automatic send_sample(input logic [SampleW-1:0] s);
    while (!no_idle && $urandom_range(99) < 17) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid  = 1'b1;
    in_if.sample = s;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_sample(s);
    samples_sent++;
    @(negedge clk_i);
  endtask

  // hold off the sender until every queued mean has come out
  task automatic drain_results();
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    drains++;
  endtask

  // random sample with weight on small, large and single-bit values
  function automatic logic [SampleW-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return SampleW'($urandom());
    if (r < 65) return SampleW'($urandom_range(15));
    if (r < 80) return SampleW'($urandom_range(65535, 65520));
    if (r < 90) return ($urandom_range(1) != 0) ? '1 : '0;
    return SampleW'(1) << $urandom_range(SampleW - 1);
  endfunction

  initial begin
    logic [SampleW-1:0] directed_q[$];
    sb = new();
    sb.clear();
    no_idle      = 1'b0;
    quiet_cycles = 0;
    drains       = 0;
    samples_sent = 0;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // start-up with every divisor from one to the full window
    directed_q = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                   16'hAAAA, 16'h5555, 16'h7FFF, 16'hFFFE};
    // full window of maximum samples, then zeros pushing them out
    repeat (WinDepth) directed_q.push_back(16'hFFFF);
    repeat (WinDepth) directed_q.push_back(16'h0000);
    directed_q.push_back(16'h1234);
    foreach (directed_q[i]) send_sample(directed_q[i]);
    drain_results();

    // random traffic with a steady stretch and a couple of drain pauses
    for (int unsigned n = 0; n < RandItems; n++) begin
      no_idle = (n >= 150 && n < 250);
      if (n == 100 || n == 320) drain_results();
      send_sample(pick_sample());
    end
    no_idle = 1'b0;

    // let the last results through
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("covered %0d samples from reset through a full and refilled window,",
             samples_sent);
    $display("%0d means checked, %0d drain pauses, random stalls on both channels",
             sb.checked, drains);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[moving_average_filter_top.f]
hdl/maf_pkg.sv
hdl/maf_sample_if.sv
hdl/maf_result_if.sv
hdl/maf_window.sv
hdl/maf_div.sv
hdl/maf_ctrl.sv
hdl/moving_average_filter_top.sv
tb/testbench.sv
